/* rtl/tendon_tension_bilateral_follow_assert.svh */
// assertion macros for the checker of this block
`ifndef TENDON_TENSION_BILATERAL_FOLLOW_ASSERT_SVH
`define TENDON_TENSION_BILATERAL_FOLLOW_ASSERT_SVH

// checked only while out of reset
`define TTBF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define TTBF_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/ttbf_pkg.sv */
`default_nettype none
package ttbf_pkg;

	localparam int PosW     = 32;
	localparam int TenW     = 16;
	localparam int SumW     = 22;
	localparam int BaseW    = 23;
	localparam int OffsetW  = 14;
	localparam int GainW    = 10;
	localparam int MarginW  = 13;
	localparam int CntW     = 7;
	localparam int ChW      = 2;
	localparam int OpW      = 2;
	localparam int BandW    = 2;
	localparam int AddrW    = 5;
	localparam int DataW    = 32;
	localparam int RegIdxW  = 3;
	localparam int NumLanes = 4;
	localparam int LaneW    = 2;

	localparam int MaxAverage = 64;

	// tension error, negated for the minus lanes
	localparam int DiffW    = BaseW + 2;
	// error shifted by up to GainW-1 places
	localparam int McandW   = DiffW + GainW - 1;
	localparam int AccW     = 36;
	localparam int DivStepW = $clog2(SumW);
	localparam int MulStepW = $clog2(GainW);

	localparam logic [OpW-1:0] OpPosition = 2'd0;
	localparam logic [OpW-1:0] OpTension  = 2'd1;
	localparam logic [OpW-1:0] OpTick     = 2'd2;

	localparam logic [RegIdxW-1:0] RegTensionOffset   = 3'd0;
	localparam logic [RegIdxW-1:0] RegPullGain        = 3'd1;
	localparam logic [RegIdxW-1:0] RegUpperMargin     = 3'd2;
	localparam logic [RegIdxW-1:0] RegAverageCount    = 3'd3;
	localparam logic [RegIdxW-1:0] RegMasterOneChannel = 3'd4;
	localparam logic [RegIdxW-1:0] RegMasterTwoChannel = 3'd5;
	localparam logic [RegIdxW-1:0] RegSlaveOneChannel  = 3'd6;
	localparam logic [RegIdxW-1:0] RegSlaveTwoChannel  = 3'd7;

	localparam logic signed [OffsetW-1:0] OffsetReset = 14'sd10;
	localparam logic [GainW-1:0]   GainReset          = 10'd10;
	localparam logic [MarginW-1:0] MarginReset        = 13'd30;
	localparam logic [CntW-1:0]    CountReset         = 7'd5;
	localparam logic [ChW-1:0]     MasterOneChReset   = 2'd0;
	localparam logic [ChW-1:0]     MasterTwoChReset   = 2'd1;
	localparam logic [ChW-1:0]     SlaveOneChReset    = 2'd2;
	localparam logic [ChW-1:0]     SlaveTwoChReset    = 2'd3;

	typedef enum logic [BandW-1:0] {
		BandInRange = 2'd0,
		BandLow     = 2'd1,
		BandHigh    = 2'd2
	} band_t;

	typedef enum logic [3:0] {
		StIdle,
		StAbsolute,
		StDivide,
		StBaseline,
		StLimit,
		StCompare,
		StInit,
		StAdjust,
		StMultiply,
		StOutput
	} state_t;

	// clamp a wide signed value to the signed position range
	function automatic logic [PosW-1:0] saturate_pos(input logic signed [AccW-1:0] v);
		logic [AccW-PosW:0] top;
		logic [PosW-1:0] res;
		top = v[AccW-1:PosW-1];
		if (top == '0 || top == '1) begin
			res = v[PosW-1:0];
		end else if (v[AccW-1]) begin
			res = {1'b1, {(PosW-1){1'b0}}};
		end else begin
			res = {1'b0, {(PosW-1){1'b1}}};
		end
		return res;
	endfunction

endpackage
`default_nettype wire

/* rtl/tendon_tension_bilateral_follow.sv */
// channel | handshake               | payload
// --------+-------------------------+-------------------------------------------------
// in      | in_valid / in_ready     | opcode, position_0..3, tension_0..3
// out     | out_valid / out_ready   | command_0..3, slave_*_slack, master_*_band
// cfg     | psel penable pwrite     | paddr[4:2] register index, pwdata, prdata
//
// position sample and plain tension sample: taken in idle, the block stays ready
// tension sample that forms the baselines: runs the 22-step bit-serial
//   divider (four channel lanes side by side) plus the abs, baseline and limit states
// control tick: a lane-by-lane tension compare, then the 10-step bit-serial multiplier
//   over the gain bits; a tick before ready is taken in idle and gives no result
// reset clears control state and loads the register defaults; no clearing pass
// a finished result waits in the output register; the next item is taken meanwhile,
//   and a later tick holds in its last cycle until that register frees up
`default_nettype none
module tendon_tension_bilateral_follow (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// input items
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [ttbf_pkg::OpW-1:0]               opcode,
	input  wire logic signed [ttbf_pkg::PosW-1:0]       position_0,
	input  wire logic signed [ttbf_pkg::PosW-1:0]       position_1,
	input  wire logic signed [ttbf_pkg::PosW-1:0]       position_2,
	input  wire logic signed [ttbf_pkg::PosW-1:0]       position_3,
	input  wire logic signed [ttbf_pkg::TenW-1:0]       tension_0,
	input  wire logic signed [ttbf_pkg::TenW-1:0]       tension_1,
	input  wire logic signed [ttbf_pkg::TenW-1:0]       tension_2,
	input  wire logic signed [ttbf_pkg::TenW-1:0]       tension_3,
	// result items
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [ttbf_pkg::PosW-1:0]            command_0,
	output logic signed [ttbf_pkg::PosW-1:0]            command_1,
	output logic signed [ttbf_pkg::PosW-1:0]            command_2,
	output logic signed [ttbf_pkg::PosW-1:0]            command_3,
	output logic                                        slave_one_slack,
	output logic                                        slave_two_slack,
	output logic [ttbf_pkg::BandW-1:0]                  master_one_band,
	output logic [ttbf_pkg::BandW-1:0]                  master_two_band,
	// register port
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [ttbf_pkg::AddrW-1:0]             paddr,
	input  wire logic [ttbf_pkg::DataW-1:0]             pwdata,
	output logic [ttbf_pkg::DataW-1:0]                  prdata,
	output logic                                        pready
);

	ttbf_pkg::state_t state_q, state_d;

	// configuration registers
	logic signed [ttbf_pkg::OffsetW-1:0] tension_offset_q;
	logic [ttbf_pkg::GainW-1:0]          pull_gain_q;
	logic [ttbf_pkg::MarginW-1:0]        upper_margin_q;
	logic [ttbf_pkg::CntW-1:0]           average_count_q;
	logic [ttbf_pkg::ChW-1:0]            master_one_channel_q;
	logic [ttbf_pkg::ChW-1:0]            master_two_channel_q;
	logic [ttbf_pkg::ChW-1:0]            slave_one_channel_q;
	logic [ttbf_pkg::ChW-1:0]            slave_two_channel_q;

	logic                                cfg_write;
	logic [ttbf_pkg::RegIdxW-1:0]        cfg_index;

	// sample state
	logic signed [ttbf_pkg::PosW-1:0]    pos_in [ttbf_pkg::NumLanes];
	logic signed [ttbf_pkg::TenW-1:0]    ten_in [ttbf_pkg::NumLanes];
	logic signed [ttbf_pkg::PosW-1:0]    last_pos_q [ttbf_pkg::NumLanes];
	logic signed [ttbf_pkg::PosW-1:0]    home_q [ttbf_pkg::NumLanes];
	logic signed [ttbf_pkg::TenW-1:0]    last_ten_q [ttbf_pkg::NumLanes];
	logic signed [ttbf_pkg::SumW-1:0]    sum_q [ttbf_pkg::NumLanes];
	logic signed [ttbf_pkg::SumW-1:0]    sum_next [ttbf_pkg::NumLanes];
	logic signed [ttbf_pkg::BaseW-1:0]   base_q [ttbf_pkg::NumLanes];
	logic signed [ttbf_pkg::BaseW-1:0]   upper_q [2];
	logic                                home_cap_q;
	logic                                ready_q;
	logic [ttbf_pkg::CntW-1:0]           samples_q;
	logic [ttbf_pkg::CntW-1:0]           samples_next;
	logic [ttbf_pkg::CntW-1:0]           cnt_eff;
	logic                                baseline_due;

	// bit-serial divider, one lane per channel
	logic [ttbf_pkg::SumW-1:0]           dvd_q [ttbf_pkg::NumLanes];
	logic [ttbf_pkg::CntW-1:0]           rem_q [ttbf_pkg::NumLanes];
	logic [ttbf_pkg::CntW:0]             rem_sh [ttbf_pkg::NumLanes];
	logic [ttbf_pkg::CntW-1:0]           rem_new [ttbf_pkg::NumLanes];
	logic                                div_ge [ttbf_pkg::NumLanes];
	logic                                neg_q [ttbf_pkg::NumLanes];
	logic [ttbf_pkg::CntW-1:0]           div_cnt_q;
	logic [ttbf_pkg::DivStepW-1:0]       div_step_q;

	// shared read port into tension and baseline
	logic [ttbf_pkg::ChW-1:0]            rd_ch;
	logic signed [ttbf_pkg::BaseW-1:0]   rd_ten;
	logic signed [ttbf_pkg::BaseW-1:0]   rd_base;
	logic signed [ttbf_pkg::BaseW-1:0]   rd_upper;
	logic signed [ttbf_pkg::BaseW-1:0]   lim_value;
	logic signed [ttbf_pkg::BaseW-1:0]   cmp_ref;
	logic signed [ttbf_pkg::DiffW-1:0]   cmp_diff;
	logic signed [ttbf_pkg::DiffW-1:0]   cmp_term;
	logic                                cmp_low;
	logic                                cmp_high;

	// command lanes and bit-serial multiplier
	logic [ttbf_pkg::LaneW-1:0]          lane_q;
	logic                                low_q [ttbf_pkg::NumLanes];
	logic                                high_q [ttbf_pkg::NumLanes];
	logic signed [ttbf_pkg::McandW-1:0]  mcand_q [ttbf_pkg::NumLanes];
	logic signed [ttbf_pkg::AccW-1:0]    acc_q [ttbf_pkg::NumLanes];
	logic [ttbf_pkg::GainW-1:0]          gain_sh_q;
	logic [ttbf_pkg::MulStepW-1:0]       mul_step_q;

	// output register
	logic                                out_valid_q;
	logic                                out_free;
	logic                                accept_in;
	logic signed [ttbf_pkg::PosW-1:0]    cmd_q [ttbf_pkg::NumLanes];
	logic                                slack_q [2];
	ttbf_pkg::band_t                     band_q [2];

	assign pos_in[0] = position_0;
	assign pos_in[1] = position_1;
	assign pos_in[2] = position_2;
	assign pos_in[3] = position_3;
	assign ten_in[0] = tension_0;
	assign ten_in[1] = tension_1;
	assign ten_in[2] = tension_2;
	assign ten_in[3] = tension_3;

	assign accept_in = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;

	assign out_valid       = out_valid_q;
	assign command_0       = cmd_q[0];
	assign command_1       = cmd_q[1];
	assign command_2       = cmd_q[2];
	assign command_3       = cmd_q[3];
	assign slave_one_slack = slack_q[0];
	assign slave_two_slack = slack_q[1];
	assign master_one_band = band_q[0];
	assign master_two_band = band_q[1];

	// ------------------------------------------------------------------
	// register port: zero wait states, word addressed
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;
	assign cfg_index = paddr[ttbf_pkg::AddrW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tension_offset_q     <= ttbf_pkg::OffsetReset;
			pull_gain_q          <= ttbf_pkg::GainReset;
			upper_margin_q       <= ttbf_pkg::MarginReset;
			average_count_q      <= ttbf_pkg::CountReset;
			master_one_channel_q <= ttbf_pkg::MasterOneChReset;
			master_two_channel_q <= ttbf_pkg::MasterTwoChReset;
			slave_one_channel_q  <= ttbf_pkg::SlaveOneChReset;
			slave_two_channel_q  <= ttbf_pkg::SlaveTwoChReset;
		end else if (cfg_write) begin
			case (cfg_index)
				ttbf_pkg::RegTensionOffset: begin
					tension_offset_q <= pwdata[ttbf_pkg::OffsetW-1:0];
				end
				ttbf_pkg::RegPullGain: begin
					pull_gain_q <= pwdata[ttbf_pkg::GainW-1:0];
				end
				ttbf_pkg::RegUpperMargin: begin
					upper_margin_q <= pwdata[ttbf_pkg::MarginW-1:0];
				end
				ttbf_pkg::RegAverageCount: begin
					average_count_q <= pwdata[ttbf_pkg::CntW-1:0];
				end
				ttbf_pkg::RegMasterOneChannel: begin
					master_one_channel_q <= pwdata[ttbf_pkg::ChW-1:0];
				end
				ttbf_pkg::RegMasterTwoChannel: begin
					master_two_channel_q <= pwdata[ttbf_pkg::ChW-1:0];
				end
				ttbf_pkg::RegSlaveOneChannel: begin
					slave_one_channel_q <= pwdata[ttbf_pkg::ChW-1:0];
				end
				ttbf_pkg::RegSlaveTwoChannel: begin
					slave_two_channel_q <= pwdata[ttbf_pkg::ChW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_index)
			ttbf_pkg::RegTensionOffset:    prdata = ttbf_pkg::DataW'(tension_offset_q);
			ttbf_pkg::RegPullGain:         prdata = ttbf_pkg::DataW'(pull_gain_q);
			ttbf_pkg::RegUpperMargin:      prdata = ttbf_pkg::DataW'(upper_margin_q);
			ttbf_pkg::RegAverageCount:     prdata = ttbf_pkg::DataW'(average_count_q);
			ttbf_pkg::RegMasterOneChannel: prdata = ttbf_pkg::DataW'(master_one_channel_q);
			ttbf_pkg::RegMasterTwoChannel: prdata = ttbf_pkg::DataW'(master_two_channel_q);
			ttbf_pkg::RegSlaveOneChannel:  prdata = ttbf_pkg::DataW'(slave_one_channel_q);
			ttbf_pkg::RegSlaveTwoChannel:  prdata = ttbf_pkg::DataW'(slave_two_channel_q);
			default:                       prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// start-up averaging
	// ------------------------------------------------------------------
	always_comb begin
		// zero acts as one, anything above the cap acts as the cap
		if (average_count_q == '0) begin
			cnt_eff = ttbf_pkg::CntW'(1);
		end else if (average_count_q > ttbf_pkg::CntW'(ttbf_pkg::MaxAverage)) begin
			cnt_eff = ttbf_pkg::CntW'(ttbf_pkg::MaxAverage);
		end else begin
			cnt_eff = average_count_q;
		end
		samples_next = (samples_q == '1) ? samples_q : samples_q + 1'b1;
		baseline_due = samples_next >= cnt_eff;
		for (int k = 0; k < ttbf_pkg::NumLanes; k++) begin
			sum_next[k] = sum_q[k] + ttbf_pkg::SumW'(ten_in[k]);
		end
	end

	// one quotient bit per cycle in each lane, restoring
	always_comb begin
		for (int k = 0; k < ttbf_pkg::NumLanes; k++) begin
			rem_sh[k]  = {rem_q[k], dvd_q[k][ttbf_pkg::SumW-1]};
			div_ge[k]  = rem_sh[k] >= {1'b0, div_cnt_q};
			rem_new[k] = div_ge[k] ? ttbf_pkg::CntW'(rem_sh[k] - {1'b0, div_cnt_q})
			                       : ttbf_pkg::CntW'(rem_sh[k]);
		end
	end

	// ------------------------------------------------------------------
	// channel read and tension compare, one lane per cycle
	// lanes: 0 master one, 1 slave one, 2 master two, 3 slave two
	// ------------------------------------------------------------------
	always_comb begin
		if (state_q == ttbf_pkg::StLimit) begin
			rd_ch = lane_q[0] ? master_two_channel_q : master_one_channel_q;
		end else begin
			case (lane_q)
				2'd0:    rd_ch = master_one_channel_q;
				2'd1:    rd_ch = slave_one_channel_q;
				2'd2:    rd_ch = master_two_channel_q;
				default: rd_ch = slave_two_channel_q;
			endcase
		end
		rd_ten    = ttbf_pkg::BaseW'(last_ten_q[rd_ch]);
		rd_base   = base_q[rd_ch];
		rd_upper  = upper_q[lane_q[1]];
		lim_value = rd_base + $signed({{(ttbf_pkg::BaseW-ttbf_pkg::MarginW){1'b0}},
			upper_margin_q});

		cmp_low  = rd_ten < rd_base;
		// only master lanes have an upper limit
		cmp_high = ~lane_q[0] & ~cmp_low & (rd_ten > rd_upper);
		cmp_ref  = cmp_low ? rd_base : rd_upper;
		cmp_diff = ttbf_pkg::DiffW'(rd_ten) - ttbf_pkg::DiffW'(cmp_ref);
		// second-pair lanes move against the tension error
		if (cmp_low | cmp_high) begin
			cmp_term = lane_q[1] ? -cmp_diff : cmp_diff;
		end else begin
			cmp_term = '0;
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttbf_pkg::StIdle;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ttbf_pkg::StIdle: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == ttbf_pkg::OpTension && !ready_q && baseline_due) begin
						state_d = ttbf_pkg::StAbsolute;
					end else if (opcode == ttbf_pkg::OpTick && home_cap_q && ready_q) begin
						state_d = ttbf_pkg::StCompare;
					end
				end
			end
			ttbf_pkg::StAbsolute: begin
				state_d = ttbf_pkg::StDivide;
			end
			ttbf_pkg::StDivide: begin
				if (div_step_q == '0) begin
					state_d = ttbf_pkg::StBaseline;
				end
			end
			ttbf_pkg::StBaseline: begin
				state_d = ttbf_pkg::StLimit;
			end
			ttbf_pkg::StLimit: begin
				if (lane_q[0]) begin
					state_d = ttbf_pkg::StIdle;
				end
			end
			ttbf_pkg::StCompare: begin
				if (lane_q == ttbf_pkg::LaneW'(ttbf_pkg::NumLanes - 1)) begin
					state_d = ttbf_pkg::StInit;
				end
			end
			ttbf_pkg::StInit: begin
				state_d = ttbf_pkg::StAdjust;
			end
			ttbf_pkg::StAdjust: begin
				state_d = ttbf_pkg::StMultiply;
			end
			ttbf_pkg::StMultiply: begin
				if (mul_step_q == '0) begin
					state_d = ttbf_pkg::StOutput;
				end
			end
			ttbf_pkg::StOutput: begin
				if (out_free) begin
					state_d = ttbf_pkg::StIdle;
				end
			end
			default: begin
				state_d = ttbf_pkg::StIdle;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_cap_q  <= 1'b0;
			ready_q     <= 1'b0;
			samples_q   <= '0;
			lane_q      <= '0;
			div_step_q  <= '0;
			mul_step_q  <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < ttbf_pkg::NumLanes; k++) begin
				sum_q[k] <= '0;
			end
		end else begin
			if (accept_in && opcode == ttbf_pkg::OpPosition) begin
				home_cap_q <= 1'b1;
			end
			if (accept_in && opcode == ttbf_pkg::OpTension && !ready_q) begin
				samples_q <= samples_next;
				for (int k = 0; k < ttbf_pkg::NumLanes; k++) begin
					sum_q[k] <= sum_next[k];
				end
			end
			if (state_q == ttbf_pkg::StLimit && lane_q[0]) begin
				ready_q <= 1'b1;
			end
			if (state_q == ttbf_pkg::StCompare || state_q == ttbf_pkg::StLimit) begin
				lane_q <= lane_q + 1'b1;
			end else begin
				lane_q <= '0;
			end
			if (state_q == ttbf_pkg::StAbsolute) begin
				div_step_q <= ttbf_pkg::DivStepW'(ttbf_pkg::SumW - 1);
			end else if (state_q == ttbf_pkg::StDivide) begin
				div_step_q <= div_step_q - 1'b1;
			end
			if (state_q == ttbf_pkg::StInit) begin
				mul_step_q <= ttbf_pkg::MulStepW'(ttbf_pkg::GainW - 1);
			end else if (state_q == ttbf_pkg::StMultiply) begin
				mul_step_q <= mul_step_q - 1'b1;
			end
			if (state_q == ttbf_pkg::StOutput && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept_in && opcode == ttbf_pkg::OpPosition) begin
			for (int k = 0; k < ttbf_pkg::NumLanes; k++) begin
				last_pos_q[k] <= pos_in[k];
				// home latches on the first position sample only
				if (!home_cap_q) begin
					home_q[k] <= pos_in[k];
				end
			end
		end
		if (accept_in && opcode == ttbf_pkg::OpTension) begin
			for (int k = 0; k < ttbf_pkg::NumLanes; k++) begin
				last_ten_q[k] <= ten_in[k];
			end
		end

		case (state_q)
			ttbf_pkg::StIdle: begin
				div_cnt_q <= cnt_eff;
			end
			ttbf_pkg::StAbsolute: begin
				// sign and magnitude, so the quotient truncates toward zero
				for (int k = 0; k < ttbf_pkg::NumLanes; k++) begin
					neg_q[k] <= sum_q[k][ttbf_pkg::SumW-1];
					dvd_q[k] <= sum_q[k][ttbf_pkg::SumW-1] ? ttbf_pkg::SumW'(-sum_q[k])
					                                       : sum_q[k];
					rem_q[k] <= '0;
				end
			end
			ttbf_pkg::StDivide: begin
				for (int k = 0; k < ttbf_pkg::NumLanes; k++) begin
					dvd_q[k] <= {dvd_q[k][ttbf_pkg::SumW-2:0], div_ge[k]};
					rem_q[k] <= rem_new[k];
				end
			end
			ttbf_pkg::StBaseline: begin
				for (int k = 0; k < ttbf_pkg::NumLanes; k++) begin
					if (neg_q[k]) begin
						base_q[k] <= ttbf_pkg::BaseW'(tension_offset_q)
							- $signed(ttbf_pkg::BaseW'(dvd_q[k]));
					end else begin
						base_q[k] <= ttbf_pkg::BaseW'(tension_offset_q)
							+ $signed(ttbf_pkg::BaseW'(dvd_q[k]));
					end
				end
			end
			ttbf_pkg::StLimit: begin
				upper_q[lane_q[0]] <= lim_value;
			end
			ttbf_pkg::StCompare: begin
				low_q[lane_q]   <= cmp_low;
				high_q[lane_q]  <= cmp_high;
				mcand_q[lane_q] <= ttbf_pkg::McandW'(cmp_term);
			end
			ttbf_pkg::StInit: begin
				// slaves without slack follow the master displacement
				acc_q[0] <= ttbf_pkg::AccW'(last_pos_q[0]);
				acc_q[2] <= ttbf_pkg::AccW'(last_pos_q[2]);
				if (low_q[1]) begin
					acc_q[1] <= ttbf_pkg::AccW'(last_pos_q[1]);
				end else begin
					acc_q[1] <= ttbf_pkg::AccW'(last_pos_q[0]) - ttbf_pkg::AccW'(home_q[0]);
				end
				if (low_q[3]) begin
					acc_q[3] <= ttbf_pkg::AccW'(last_pos_q[3]);
				end else begin
					acc_q[3] <= ttbf_pkg::AccW'(last_pos_q[2]) - ttbf_pkg::AccW'(home_q[2]);
				end
				gain_sh_q <= pull_gain_q;
			end
			ttbf_pkg::StAdjust: begin
				if (!low_q[1]) begin
					acc_q[1] <= acc_q[1] + ttbf_pkg::AccW'(home_q[1]);
				end
				if (!low_q[3]) begin
					acc_q[3] <= acc_q[3] + ttbf_pkg::AccW'(home_q[3]);
				end
			end
			ttbf_pkg::StMultiply: begin
				// gain lsb first, error doubles each step
				for (int k = 0; k < ttbf_pkg::NumLanes; k++) begin
					if (gain_sh_q[0]) begin
						acc_q[k] <= acc_q[k] + ttbf_pkg::AccW'(mcand_q[k]);
					end
					mcand_q[k] <= mcand_q[k] <<< 1;
				end
				gain_sh_q <= gain_sh_q >> 1;
			end
			ttbf_pkg::StOutput: begin
				if (out_free) begin
					for (int k = 0; k < ttbf_pkg::NumLanes; k++) begin
						cmd_q[k] <= ttbf_pkg::saturate_pos(acc_q[k]);
					end
					slack_q[0] <= low_q[1];
					slack_q[1] <= low_q[3];
					for (int m = 0; m < 2; m++) begin
						if (low_q[2*m]) begin
							band_q[m] <= ttbf_pkg::BandLow;
						end else if (high_q[2*m]) begin
							band_q[m] <= ttbf_pkg::BandHigh;
						end else begin
							band_q[m] <= ttbf_pkg::BandInRange;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/ttbf_checker.sv */
`default_nettype none
`include "tendon_tension_bilateral_follow_assert.svh"
module ttbf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] command_0
);

	// a stalled result stays put
	`TTBF_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(command_0), "result changed while stalled")

	// a result only appears after the block was busy working on a tick
	`TTBF_ASSERT(a_out_after_busy, clk, arst_n, $rose(out_valid) |-> $past(!in_ready), "result appeared without work")

	// the block only goes busy on an accepted item
	`TTBF_ASSERT(a_busy_on_accept, clk, arst_n, $fell(in_ready) |-> $past(in_valid), "went busy without an item")

	// reset empties the output and leaves the input open
	`TTBF_ASSERT_ALWAYS(a_reset_state, clk, !arst_n |=> !out_valid && in_ready, "bad state in reset")

endmodule

bind tendon_tension_bilateral_follow ttbf_checker u_ttbf_checker (.*);
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;

	// opcode 3 has no name in the package, the block must ignore it
	localparam logic [ttbf_pkg::OpW-1:0] OpUnused = 2'd3;
	// settle time after a drain, longer than the whole baseline divide
	localparam int SettleCycles = 40;
	localparam int HoldOffCycles = 400;
	localparam int RandomPhases = 6;
	localparam int PhaseItems = 138;

	// one input item as the sender offers it
	typedef struct packed {
		logic [ttbf_pkg::OpW-1:0] op;
		logic [3:0][ttbf_pkg::PosW-1:0] pos;
		logic [3:0][ttbf_pkg::TenW-1:0] ten;
	} sample_item_t;

	// one result item, command index follows motor order
	typedef struct packed {
		logic [3:0][ttbf_pkg::PosW-1:0] command;
		logic slave_one_slack;
		logic slave_two_slack;
		ttbf_pkg::band_t master_one_band;
		ttbf_pkg::band_t master_two_band;
	} command_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic [ttbf_pkg::OpW-1:0] opcode = '0;
	logic signed [ttbf_pkg::PosW-1:0] position_0 = '0;
	logic signed [ttbf_pkg::PosW-1:0] position_1 = '0;
	logic signed [ttbf_pkg::PosW-1:0] position_2 = '0;
	logic signed [ttbf_pkg::PosW-1:0] position_3 = '0;
	logic signed [ttbf_pkg::TenW-1:0] tension_0 = '0;
	logic signed [ttbf_pkg::TenW-1:0] tension_1 = '0;
	logic signed [ttbf_pkg::TenW-1:0] tension_2 = '0;
	logic signed [ttbf_pkg::TenW-1:0] tension_3 = '0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [ttbf_pkg::PosW-1:0] command_0;
	logic signed [ttbf_pkg::PosW-1:0] command_1;
	logic signed [ttbf_pkg::PosW-1:0] command_2;
	logic signed [ttbf_pkg::PosW-1:0] command_3;
	logic slave_one_slack;
	logic slave_two_slack;
	logic [ttbf_pkg::BandW-1:0] master_one_band;
	logic [ttbf_pkg::BandW-1:0] master_two_band;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ttbf_pkg::AddrW-1:0] paddr = '0;
	logic [ttbf_pkg::DataW-1:0] pwdata = '0;
	logic [ttbf_pkg::DataW-1:0] prdata;
	logic pready;

	tendon_tension_bilateral_follow u_dut (.*);

	// free-running clock, 10 ns period
	always #5 clk = ~clk;

	// items waiting for the driver, command sets waiting for the monitor
	sample_item_t pending_items[$];
	command_set_t expected_commands[$];

	// follower state as predicted, all clear at reset
	longint home_pos[4];
	longint last_pos[4];
	longint last_ten[4];
	longint ten_sum[4];
	longint baseline[4];
	longint upper_limit[2];
	bit home_set;
	bit baseline_set;
	int samples_seen;

	// register copies, loaded with the reset defaults
	longint offset_reg = longint'(ttbf_pkg::OffsetReset);
	longint gain_reg = longint'(ttbf_pkg::GainReset);
	longint margin_reg = longint'(ttbf_pkg::MarginReset);
	int count_reg = int'(ttbf_pkg::CountReset);
	int m1_ch = int'(ttbf_pkg::MasterOneChReset);
	int m2_ch = int'(ttbf_pkg::MasterTwoChReset);
	int s1_ch = int'(ttbf_pkg::SlaveOneChReset);
	int s2_ch = int'(ttbf_pkg::SlaveTwoChReset);

	// handshake bookkeeping and run statistics
	bit item_taken = 1'b0;
	int send_idle_pct = 24;
	int recv_idle_pct = 24;
	int hold_off_left = 0;
	int mismatches = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int regs_written = 0;

	function automatic logic [ttbf_pkg::PosW-1:0] saturate32(input longint v);
		if (v > 64'sd2147483647) begin
			v = 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			v = -64'sd2147483648;
		end
		return v[ttbf_pkg::PosW-1:0];
	endfunction

	function automatic logic [ttbf_pkg::TenW-1:0] clamp16(input longint v);
		if (v > 64'sd32767) begin
			v = 64'sd32767;
		end else if (v < -64'sd32768) begin
			v = -64'sd32768;
		end
		return v[ttbf_pkg::TenW-1:0];
	endfunction

	// advance the follower by one accepted item, queue a command set on a live tick
	task automatic predict_commands(input sample_item_t it);
		int cnt;
		longint t;
		longint b;
		longint c[4];
		command_set_t res;
		case (it.op)
			ttbf_pkg::OpPosition: begin
				for (int i = 0; i < 4; i++) begin
					last_pos[i] = longint'($signed(it.pos[i]));
					// home latches once, later samples only move the latest position
					if (!home_set) begin
						home_pos[i] = last_pos[i];
					end
				end
				home_set = 1'b1;
			end
			ttbf_pkg::OpTension: begin
				for (int i = 0; i < 4; i++) begin
					last_ten[i] = longint'($signed(it.ten[i]));
				end
				if (!baseline_set) begin
					// zero acts as one, anything past the cap acts as the cap
					cnt = count_reg;
					if (cnt == 0) begin
						cnt = 1;
					end
					if (cnt > ttbf_pkg::MaxAverage) begin
						cnt = ttbf_pkg::MaxAverage;
					end
					for (int i = 0; i < 4; i++) begin
						ten_sum[i] += last_ten[i];
					end
					if (samples_seen < 127) begin
						samples_seen++;
					end
					// count may have been lowered below what was already summed
					if (samples_seen >= cnt) begin
						for (int i = 0; i < 4; i++) begin
							baseline[i] = ten_sum[i] / longint'(cnt) + offset_reg;
						end
						// limits freeze the master channels in force right now
						upper_limit[0] = baseline[m1_ch] + margin_reg;
						upper_limit[1] = baseline[m2_ch] + margin_reg;
						baseline_set = 1'b1;
					end
				end
			end
			ttbf_pkg::OpTick: begin
				if (home_set && baseline_set) begin
					// slave one pulls in when slack, else mirrors master one
					t = last_ten[s1_ch];
					b = baseline[s1_ch];
					res.slave_one_slack = (t < b);
					if (t < b) begin
						c[1] = last_pos[1] + gain_reg * (t - b);
					end else begin
						c[1] = last_pos[0] - home_pos[0] + home_pos[1];
					end
					// slave two pulls the other way
					t = last_ten[s2_ch];
					b = baseline[s2_ch];
					res.slave_two_slack = (t < b);
					if (t < b) begin
						c[3] = last_pos[3] - gain_reg * (t - b);
					end else begin
						c[3] = last_pos[2] - home_pos[2] + home_pos[3];
					end
					// master one takes up slack, backs off above its limit
					t = last_ten[m1_ch];
					b = baseline[m1_ch];
					if (t < b) begin
						res.master_one_band = ttbf_pkg::BandLow;
						c[0] = last_pos[0] + gain_reg * (t - b);
					end else if (t > upper_limit[0]) begin
						res.master_one_band = ttbf_pkg::BandHigh;
						c[0] = last_pos[0] + gain_reg * (t - upper_limit[0]);
					end else begin
						res.master_one_band = ttbf_pkg::BandInRange;
						c[0] = last_pos[0];
					end
					// master two mirrored in sign
					t = last_ten[m2_ch];
					b = baseline[m2_ch];
					if (t < b) begin
						res.master_two_band = ttbf_pkg::BandLow;
						c[2] = last_pos[2] - gain_reg * (t - b);
					end else if (t > upper_limit[1]) begin
						res.master_two_band = ttbf_pkg::BandHigh;
						c[2] = last_pos[2] - gain_reg * (t - upper_limit[1]);
					end else begin
						res.master_two_band = ttbf_pkg::BandInRange;
						c[2] = last_pos[2];
					end
					for (int i = 0; i < 4; i++) begin
						res.command[i] = saturate32(c[i]);
					end
					expected_commands = {expected_commands, res};
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
			mismatches++;
		end
	endtask

	// driver: offers the next pending item once the current one is gone
	always @(negedge clk) begin
		sample_item_t next_item;
		if (arst_n && (!in_valid || item_taken)) begin
			item_taken = 1'b0;
			if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_item = pending_items.pop_front();
				opcode <= next_item.op;
				position_0 <= next_item.pos[0];
				position_1 <= next_item.pos[1];
				position_2 <= next_item.pos[2];
				position_3 <= next_item.pos[3];
				tension_0 <= next_item.ten[0];
				tension_1 <= next_item.ten[1];
				tension_2 <= next_item.ten[2];
				tension_3 <= next_item.ten[3];
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: a requested hold-off is counted down here, else random stalls
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			hold_off_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// monitor: predict on every accepted item, check every accepted command set
	always @(posedge clk) begin
		sample_item_t seen;
		command_set_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				item_taken = 1'b1;
				items_accepted++;
				seen.op = opcode;
				seen.pos = {position_3, position_2, position_1, position_0};
				seen.ten = {tension_3, tension_2, tension_1, tension_0};
				predict_commands(seen);
			end
			if (out_valid && out_ready) begin
				if (expected_commands.size() == 0) begin
					$error("command set arrived with none expected");
					mismatches++;
				end else begin
					want = expected_commands.pop_front();
					results_checked++;
					check_field("command_0", want.command[0], command_0);
					check_field("command_1", want.command[1], command_1);
					check_field("command_2", want.command[2], command_2);
					check_field("command_3", want.command[3], command_3);
					check_field("slave_one_slack", want.slave_one_slack, slave_one_slack);
					check_field("slave_two_slack", want.slave_two_slack, slave_two_slack);
					check_field("master_one_band", want.master_one_band, master_one_band);
					check_field("master_two_band", want.master_two_band, master_two_band);
				end
			end
		end
	end

	// register write: setup cycle then access cycle, copy updated after the write edge
	task automatic write_reg(input logic [ttbf_pkg::RegIdxW-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ttbf_pkg::RegTensionOffset: offset_reg = longint'($signed(value[ttbf_pkg::OffsetW-1:0]));
			ttbf_pkg::RegPullGain: gain_reg = longint'(value[ttbf_pkg::GainW-1:0]);
			ttbf_pkg::RegUpperMargin: margin_reg = longint'(value[ttbf_pkg::MarginW-1:0]);
			ttbf_pkg::RegAverageCount: count_reg = int'(value[ttbf_pkg::CntW-1:0]);
			ttbf_pkg::RegMasterOneChannel: m1_ch = int'(value[ttbf_pkg::ChW-1:0]);
			ttbf_pkg::RegMasterTwoChannel: m2_ch = int'(value[ttbf_pkg::ChW-1:0]);
			ttbf_pkg::RegSlaveOneChannel: s1_ch = int'(value[ttbf_pkg::ChW-1:0]);
			default: s2_ch = int'(value[ttbf_pkg::ChW-1:0]);
		endcase
		regs_written++;
	endtask

	task automatic write_settings(input int off, input int gain, input int margin, input int count,
			input int m1c, input int m2c, input int s1c, input int s2c);
		write_reg(ttbf_pkg::RegTensionOffset, off);
		write_reg(ttbf_pkg::RegPullGain, gain);
		write_reg(ttbf_pkg::RegUpperMargin, margin);
		write_reg(ttbf_pkg::RegAverageCount, count);
		write_reg(ttbf_pkg::RegMasterOneChannel, m1c);
		write_reg(ttbf_pkg::RegMasterTwoChannel, m2c);
		write_reg(ttbf_pkg::RegSlaveOneChannel, s1c);
		write_reg(ttbf_pkg::RegSlaveTwoChannel, s2c);
	endtask

	task automatic queue_sample(input logic [ttbf_pkg::OpW-1:0] op,
			input logic [3:0][ttbf_pkg::PosW-1:0] pos, input logic [3:0][ttbf_pkg::TenW-1:0] ten);
		sample_item_t s;
		s.op = op;
		s.pos = pos;
		s.ten = ten;
		pending_items = {pending_items, s};
	endtask

	function automatic logic [3:0][ttbf_pkg::TenW-1:0] small_tensions();
		logic [3:0][ttbf_pkg::TenW-1:0] tv;
		for (int i = 0; i < 4; i++) begin
			tv[i] = clamp16(longint'(int'($urandom_range(0, 600)) - 300));
		end
		return tv;
	endfunction

	// random item, mostly ticks and samples aimed near the baselines and limits
	task automatic queue_random_sample();
		int r;
		logic [ttbf_pkg::OpW-1:0] op;
		logic [3:0][ttbf_pkg::PosW-1:0] pos;
		logic [3:0][ttbf_pkg::TenW-1:0] ten;
		longint d;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			op = OpUnused;
		end else if (r < 25) begin
			op = ttbf_pkg::OpPosition;
		end else if (r < 52) begin
			op = ttbf_pkg::OpTension;
		end else begin
			op = ttbf_pkg::OpTick;
		end
		for (int i = 0; i < 4; i++) begin
			case ($urandom_range(0, 3))
				0, 1: pos[i] = $urandom;
				2: pos[i] = 32'(home_pos[i] + longint'(int'($urandom_range(0, 4000)) - 2000));
				default: pos[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
					: 32'h8000_0000 + $urandom_range(0, 3);
			endcase
			d = longint'(int'($urandom_range(0, 6)) - 3);
			case ($urandom_range(0, 4))
				0: ten[i] = ttbf_pkg::TenW'($urandom);
				1: ten[i] = clamp16(baseline[i] + d);
				2: ten[i] = clamp16(upper_limit[0] + d);
				3: ten[i] = clamp16(upper_limit[1] + d);
				default: ten[i] = clamp16(baseline[i] + longint'(int'($urandom_range(0, 400)) - 200));
			endcase
		end
		queue_sample(op, pos, ten);
	endtask

	// sender pauses until everything offered is taken and every command set is back
	task automatic drain();
		do begin
			@(posedge clk);
		end while (pending_items.size() != 0 || in_valid || expected_commands.size() != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	initial begin
		int low_count;
		int off;
		int gain;
		int margin;
		int count;
		int chans[4];
		logic [3:0][ttbf_pkg::TenW-1:0] tv;

		// single reset at the start of the run
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// start-up: oversized count, then lowered while averaging is under way
		write_reg(ttbf_pkg::RegTensionOffset, int'($urandom_range(0, 8192)) - 4096);
		write_reg(ttbf_pkg::RegUpperMargin, $urandom_range(0, 4096));
		write_reg(ttbf_pkg::RegAverageCount, 100);

		// tick with neither home nor baseline
		queue_sample(ttbf_pkg::OpTick, '0, '0);
		// unused opcode with a busy payload
		queue_sample(OpUnused, {$urandom, $urandom, $urandom, $urandom}, {$urandom, $urandom});
		// tension extremes that almost cancel in the sums
		queue_sample(ttbf_pkg::OpTension, '0, {16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF});
		queue_sample(ttbf_pkg::OpTension, '0, {16'h5556, 16'hAAAB, 16'h7FFF, 16'h8000});
		queue_sample(ttbf_pkg::OpTick, '0, '0);
		// home at the position extremes
		queue_sample(ttbf_pkg::OpPosition, {32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF}, '0);
		// tick with home but no baseline yet
		queue_sample(ttbf_pkg::OpTick, '0, '0);
		queue_sample(ttbf_pkg::OpTension, '0, small_tensions());
		queue_sample(ttbf_pkg::OpTension, '0, small_tensions());
		drain();

		// lowered count, zero now and then, forms the baselines on the next sample
		low_count = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 3);
		write_reg(ttbf_pkg::RegAverageCount, low_count);
		queue_sample(ttbf_pkg::OpTension, '0, small_tensions());
		drain();

		// live ticks at full gain around every band boundary
		write_reg(ttbf_pkg::RegPullGain, 1023);
		queue_sample(ttbf_pkg::OpPosition, {32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000}, '0);
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 4; i++) begin
				case (k)
					0: tv[i] = clamp16(baseline[i]);
					1: tv[i] = clamp16(baseline[i] - 1);
					2: tv[i] = clamp16(baseline[i] + margin_reg + 1);
					default: tv[i] = clamp16(baseline[i] + margin_reg);
				endcase
			end
			// master channels pinned to their own limits
			if (k >= 2) begin
				tv[m1_ch] = clamp16(upper_limit[0] + ((k == 2) ? 1 : 0));
				tv[m2_ch] = clamp16(upper_limit[1] + ((k == 2) ? 1 : 0));
			end
			queue_sample(ttbf_pkg::OpTension, '0, tv);
			queue_sample(ttbf_pkg::OpTick, '0, '0);
		end
		queue_sample(ttbf_pkg::OpTension, '0, {4{16'h7FFF}});
		queue_sample(ttbf_pkg::OpTick, '0, '0);
		queue_sample(ttbf_pkg::OpTension, '0, {4{16'h8000}});
		queue_sample(ttbf_pkg::OpTick, '0, '0);
		queue_sample(OpUnused, {$urandom, $urandom, $urandom, $urandom}, {$urandom, $urandom});
		queue_sample(ttbf_pkg::OpTick, '0, '0);
		drain();

		// random phases, each under its own register setting
		for (int p = 0; p < RandomPhases; p++) begin
			for (int i = 0; i < 4; i++) begin
				chans[i] = $urandom_range(0, 3);
			end
			off = int'($urandom_range(0, 8192)) - 4096;
			gain = $urandom_range(0, 1023);
			margin = $urandom_range(0, 4096);
			count = $urandom_range(0, 127);
			case (p)
				0: begin
					off = -4096;
					gain = 0;
					margin = 0;
					count = 0;
				end
				1: begin
					// long stretch with no idling on either side
					off = 4096;
					gain = 1023;
					margin = 4096;
					count = 64;
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				2: begin
					// every role watching one channel
					count = 127;
					chans[1] = chans[0];
					chans[2] = chans[0];
					chans[3] = chans[0];
				end
				default: begin
				end
			endcase
			write_settings(off, gain, margin, count, chans[0], chans[1], chans[2], chans[3]);
			// receiver holds off while the sender keeps offering, the block backs up
			if (p == 2) begin
				hold_off_left = HoldOffCycles;
			end
			for (int n = 0; n < PhaseItems; n++) begin
				queue_random_sample();
			end
			drain();
			send_idle_pct = 24;
			recv_idle_pct = 24;
		end

		$display("run covered %0d accepted items and %0d checked command sets", items_accepted,
			results_checked);
		$display("over %0d register writes in %0d random phases", regs_written, RandomPhases);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/ttbf_pkg.sv
rtl/tendon_tension_bilateral_follow.sv
rtl/ttbf_checker.sv
tb/sv/tb.sv
